[hw/rtl/lin_frame_transmit_sequencer_macros.svh]
// Assertion helpers shared by the LIN transmit sequencer modules.
// Every user module provides i_clk and i_rst_n.
`ifndef LIN_FRAME_TRANSMIT_SEQUENCER_MACROS_SVH
`define LIN_FRAME_TRANSMIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, off during reset
`define LFTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define LFTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lfts_pkg.sv]
`timescale 1ns / 1ps

package lfts_pkg;

    // Frame limits
    localparam int MAX_DATA_BYTES = 8;
    localparam int NUM_BYTE_FIELDS = 8;
    localparam int LEN_W = 4;
    localparam int ID_W = 6;
    localparam int CHAN_W = 2;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    // Input tdata layout: frame_id, data_length, data_byte_0..7
    localparam int ID_LSB = 0;
    localparam int LEN_LSB = ID_LSB + ID_W;
    localparam int DATA_LSB = LEN_LSB + LEN_W;
    localparam int IN_BITS = DATA_LSB + NUM_BYTE_FIELDS * BYTE_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Symbol kinds
    localparam logic [KIND_W-1:0] KIND_BREAK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam logic [CHAN_W-1:0] SERVED_CHANNEL = '0;

    // One symbol from the sequencer
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_symbol;

    // Checksum unit control
    typedef struct packed {
        logic clear;
        logic add;
    } t_csum_ctrl;

    // Protected identifier: P1 in bit 7, P0 in bit 6, id in bits 5..0
    function automatic logic [BYTE_W-1:0] protected_id(input logic [ID_W-1:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

endpackage

[hw/rtl/lfts_csum_unit.sv]
`timescale 1ns / 1ps

// Shared end-around-carry byte adder; one data byte folded in per add.
module lfts_csum_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lfts_pkg::t_csum_ctrl       i_ctrl,
    input  logic [lfts_pkg::BYTE_W-1:0] i_operand,
    output logic [lfts_pkg::BYTE_W-1:0] o_sum
);

    logic [lfts_pkg::BYTE_W-1:0] r_sum;
    logic [lfts_pkg::BYTE_W-1:0] n_sum;
    logic [lfts_pkg::BYTE_W:0]   w_raw;

    // Carry out of bit 7 goes back into bit 0
    always_comb begin
        w_raw = {1'b0, r_sum} + {1'b0, i_operand};
        n_sum = w_raw[lfts_pkg::BYTE_W-1:0] + {{(lfts_pkg::BYTE_W-1){1'b0}},
                                               w_raw[lfts_pkg::BYTE_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.add) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[hw/rtl/lfts_seq.sv]
`timescale 1ns / 1ps
`include "lin_frame_transmit_sequencer_macros.svh"

// Frame sequencer: break, sync, PID, data, csum or reject, one per step.
module lfts_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  logic [lfts_pkg::CHAN_W-1:0]     i_req_channel,
    input  logic [lfts_pkg::IN_TDATA_W-1:0] i_req_data,
    input  logic                            i_sym_free,
    output lfts_pkg::t_symbol               o_sym,
    output lfts_pkg::t_csum_ctrl            o_csum_ctrl,
    output logic [lfts_pkg::BYTE_W-1:0]     o_csum_operand,
    input  logic [lfts_pkg::BYTE_W-1:0]     i_csum_sum
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BREAK,
        S_SYNC,
        S_PID,
        S_DATA,
        S_CSUM,
        S_REJECT
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [lfts_pkg::LEN_W-1:0]    r_remain;
    logic [lfts_pkg::LEN_W-1:0]    n_remain;
    logic [lfts_pkg::BYTE_W-1:0]   r_pid;
    logic [lfts_pkg::BYTE_W-1:0]   r_data [lfts_pkg::NUM_BYTE_FIELDS];
    logic [lfts_pkg::LEN_W-1:0]    w_len_in;
    logic [lfts_pkg::LEN_W-1:0]    w_len_sat;
    logic                          w_accept;
    logic                          w_emit;

    localparam logic [lfts_pkg::LEN_W-1:0] MaxLen = lfts_pkg::LEN_W'(lfts_pkg::MAX_DATA_BYTES);
    localparam logic [lfts_pkg::LEN_W-1:0] OneLen = lfts_pkg::LEN_W'(1);

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_len_in    = i_req_data[lfts_pkg::LEN_LSB +: lfts_pkg::LEN_W];
    assign w_len_sat   = (w_len_in > MaxLen) ? MaxLen : w_len_in;

    // Symbol for the current step
    always_comb begin
        o_sym.valid = 1'b1;
        o_sym.kind  = lfts_pkg::KIND_BYTE;
        o_sym.data  = '0;
        o_sym.last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_sym.valid = 1'b0;
            end
            S_BREAK: begin
                o_sym.kind = lfts_pkg::KIND_BREAK;
            end
            S_SYNC: begin
                o_sym.data = lfts_pkg::SYNC_BYTE;
            end
            S_PID: begin
                o_sym.data = r_pid;
            end
            S_DATA: begin
                o_sym.data = r_data[0];
            end
            S_CSUM: begin
                o_sym.data = ~i_csum_sum;
                o_sym.last = 1'b1;
            end
            S_REJECT: begin
                o_sym.kind = lfts_pkg::KIND_REJECT;
                o_sym.last = 1'b1;
            end
            default: begin
                o_sym.valid = 1'b0;
            end
        endcase
    end

    assign w_emit = o_sym.valid && i_sym_free;

    // Checksum unit: cleared per request, one add per data byte sent
    assign o_csum_ctrl.clear = w_accept;
    assign o_csum_ctrl.add   = w_emit && (r_state == S_DATA);
    assign o_csum_operand    = r_data[0];

    // Next state
    always_comb begin
        n_state  = r_state;
        n_remain = r_remain;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_remain = w_len_sat;
                    n_state  = (i_req_channel != lfts_pkg::SERVED_CHANNEL) ? S_REJECT : S_BREAK;
                end
            end
            S_BREAK: begin
                if (w_emit) begin
                    n_state = S_SYNC;
                end
            end
            S_SYNC: begin
                if (w_emit) begin
                    n_state = S_PID;
                end
            end
            S_PID: begin
                if (w_emit) begin
                    n_state = (r_remain == '0) ? S_CSUM : S_DATA;
                end
            end
            S_DATA: begin
                if (w_emit) begin
                    n_remain = r_remain - OneLen;
                    if (r_remain == OneLen) begin
                        n_state = S_CSUM;
                    end
                end
            end
            S_CSUM, S_REJECT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, count and request payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_remain <= n_remain;
            if (w_accept) begin
                r_pid <= lfts_pkg::protected_id(
                    i_req_data[lfts_pkg::ID_LSB +: lfts_pkg::ID_W]);
                for (int i = 0; i < lfts_pkg::NUM_BYTE_FIELDS; i++) begin
                    r_data[i] <= i_req_data[lfts_pkg::DATA_LSB + i*lfts_pkg::BYTE_W
                                            +: lfts_pkg::BYTE_W];
                end
            end else if (w_emit && (r_state == S_DATA)) begin
                // shift next data byte to the head
                for (int i = 0; i < lfts_pkg::NUM_BYTE_FIELDS - 1; i++) begin
                    r_data[i] <= r_data[i+1];
                end
            end
        end
    end

    `LFTS_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_req_ready, "ready right after accept")
    `LFTS_ASSERT_NOW(a_data_count_live, r_state == S_DATA, r_remain != '0, "data step with no bytes left")
    `LFTS_ASSERT_NOW(a_last_ends_frame, w_emit && o_sym.last, n_state == S_IDLE, "last symbol not at frame end")
    `LFTS_ASSERT_NOW(a_len_bounded, r_state == S_DATA, r_remain <= MaxLen, "data count above limit")

endmodule

[hw/rtl/lin_frame_transmit_sequencer.sv]
`timescale 1ns / 1ps
`include "lin_frame_transmit_sequencer_macros.svh"

// LIN master frame transmitter (classic checksum). One request on the slave
// stream (channel in tuser, id/length/eight data bytes in tdata) becomes a run
// of symbols on the master stream: break, sync 0x55, protected id, the data
// bytes (length saturates at 8) and the inverted end-around-carry checksum,
// the last one flagged by tlast. A request on a channel other than 0 yields a
// single reject symbol. A new request is taken only once the previous run has
// been handed on; then the sequencer gives one symbol per cycle while the
// output register is free. The checksum is built by one shared byte adder, one
// data byte per cycle as the byte leaves, unless the output stalls. The output
// register lets the next symbol be produced in the same cycle the current one transfers.
module lin_frame_transmit_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [5:0] frame_id, [9:6] data_length, [17:10]..[73:66] data_byte_0..7, rest zero
    input  logic [lfts_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [1:0] channel
    input  logic [lfts_pkg::CHAN_W-1:0]     s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] symbol_byte
    output logic [lfts_pkg::BYTE_W-1:0]     m_axis_tdata,
    // [1:0] symbol_kind
    output logic [lfts_pkg::KIND_W-1:0]     m_axis_tuser,
    output logic                            m_axis_tlast
);

    lfts_pkg::t_symbol           w_sym;
    lfts_pkg::t_csum_ctrl        w_csum_ctrl;
    logic [lfts_pkg::BYTE_W-1:0] w_csum_operand;
    logic [lfts_pkg::BYTE_W-1:0] w_csum_sum;
    logic                        w_sym_free;

    logic                        r_out_valid;
    logic [lfts_pkg::KIND_W-1:0] r_out_kind;
    logic [lfts_pkg::BYTE_W-1:0] r_out_data;
    logic                        r_out_last;

    lfts_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_axis_tvalid),
        .o_req_ready    (s_axis_tready),
        .i_req_channel  (s_axis_tuser),
        .i_req_data     (s_axis_tdata),
        .i_sym_free     (w_sym_free),
        .o_sym          (w_sym),
        .o_csum_ctrl    (w_csum_ctrl),
        .o_csum_operand (w_csum_operand),
        .i_csum_sum     (w_csum_sum)
    );

    lfts_csum_unit u_csum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_csum_ctrl),
        .i_operand (w_csum_operand),
        .o_sum     (w_csum_sum)
    );

    // Output register: free when empty or its transfer completes now
    assign w_sym_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sym_free) begin
            r_out_valid <= w_sym.valid;
            r_out_kind  <= w_sym.kind;
            r_out_data  <= w_sym.data;
            r_out_last  <= w_sym.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `LFTS_ASSERT_NOW(a_reject_is_last, m_axis_tvalid && (m_axis_tuser == lfts_pkg::KIND_REJECT), m_axis_tlast, "reject symbol without tlast")

endmodule

[dv/lfts_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the LIN transmit sequencer. It predicts the symbol run
// for each accepted request and checks every symbol transfer against it.
module lfts_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request side
    input  logic                            i_req_tvalid,
    input  logic                            i_req_tready,
    // [5:0] frame_id, [9:6] data_length, [17:10]..[73:66] data_byte_0..7
    input  logic [lfts_pkg::IN_TDATA_W-1:0] i_req_tdata,
    // [1:0] channel
    input  logic [lfts_pkg::CHAN_W-1:0]     i_req_tuser,
    // symbol side
    input  logic                            i_sym_tvalid,
    input  logic                            i_sym_tready,
    // [7:0] symbol_byte
    input  logic [lfts_pkg::BYTE_W-1:0]     i_sym_tdata,
    // [1:0] symbol_kind
    input  logic [lfts_pkg::KIND_W-1:0]     i_sym_tuser,
    input  logic                            i_sym_tlast,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_symbol_count
);
    import lfts_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] sym_byte;
        logic              last;
    } lin_symbol_t;

    lin_symbol_t frame_symbols_due[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_symbol_count = 0;
    end

    // P0 = id0^id1^id2^id4, P1 = not(id1^id3^id4^id5)
    function automatic logic [BYTE_W-1:0] lin_pid(input logic [ID_W-1:0] id);
        logic parity0;
        logic parity1;
        parity0 = ^(id & 6'b010111);
        parity1 = ~^(id & 6'b111010);
        return {parity1, parity0, id};
    endfunction

    function automatic lin_symbol_t lin_sym(input logic [KIND_W-1:0] kind,
                                            input logic [BYTE_W-1:0] value,
                                            input logic last);
        lin_symbol_t s;
        s.kind = kind;
        s.sym_byte = value;
        s.last = last;
        return s;
    endfunction

    // Expand one request into its symbol run
    task automatic queue_frame_symbols(input logic [CHAN_W-1:0] chan,
                                       input logic [IN_TDATA_W-1:0] req);
        int unsigned len;
        logic [8:0] csum;
        logic [BYTE_W-1:0] b;
        if (chan != SERVED_CHANNEL) begin
            frame_symbols_due.push_back(lin_sym(KIND_REJECT, '0, 1'b1));
        end else begin
            len = req[LEN_LSB +: LEN_W];
            if (len > MAX_DATA_BYTES) len = MAX_DATA_BYTES;
            csum = '0;
            frame_symbols_due.push_back(lin_sym(KIND_BREAK, '0, 1'b0));
            frame_symbols_due.push_back(lin_sym(KIND_BYTE, SYNC_BYTE, 1'b0));
            frame_symbols_due.push_back(lin_sym(KIND_BYTE, lin_pid(req[ID_LSB +: ID_W]), 1'b0));
            for (int i = 0; i < len; i++) begin
                b = req[DATA_LSB + i * BYTE_W +: BYTE_W];
                frame_symbols_due.push_back(lin_sym(KIND_BYTE, b, 1'b0));
                // end-around carry
                csum = csum + b;
                if (csum > 9'h0FF) csum = csum - 9'h0FF;
            end
            frame_symbols_due.push_back(lin_sym(KIND_BYTE, ~csum[7:0], 1'b1));
        end
    endtask

    task automatic report_mismatch(input string what, input lin_symbol_t got,
                                   input lin_symbol_t want);
        $display("[%0t] symbol mismatch (%s): got kind=%0d byte=%02h last=%0d, want kind=%0d byte=%02h last=%0d",
                 $time, what, got.kind, got.sym_byte, got.last,
                 want.kind, want.sym_byte, want.last);
        o_fail_count++;
    endtask

    // Sample transfers at the clock edge
    always @(posedge i_clk) begin
        lin_symbol_t got;
        lin_symbol_t want;
        if (i_rst_n) begin
            if (i_sym_tvalid && i_sym_tready) begin
                got = lin_sym(i_sym_tuser, i_sym_tdata, i_sym_tlast);
                o_symbol_count++;
                if (frame_symbols_due.size() == 0) begin
                    report_mismatch("no symbol expected", got, '0);
                end else begin
                    want = frame_symbols_due.pop_front();
                    if (got.kind !== want.kind) report_mismatch("kind", got, want);
                    if (got.sym_byte !== want.sym_byte) report_mismatch("byte", got, want);
                    if (got.last !== want.last) report_mismatch("last", got, want);
                end
            end
            if (i_req_tvalid && i_req_tready) queue_frame_symbols(i_req_tuser, i_req_tdata);
        end
        o_pending <= frame_symbols_due.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lfts_pkg::*;

    localparam int RANDOM_PER_PHASE = 26;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic [CHAN_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    int symbol_count;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int requests_sent = 0;
    int rejects_sent = 0;

    lin_frame_transmit_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lfts_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_tvalid   (s_axis_tvalid),
        .i_req_tready   (s_axis_tready),
        .i_req_tdata    (s_axis_tdata),
        .i_req_tuser    (s_axis_tuser),
        .i_sym_tvalid   (m_axis_tvalid),
        .i_sym_tready   (m_axis_tready),
        .i_sym_tdata    (m_axis_tdata),
        .i_sym_tuser    (m_axis_tuser),
        .i_sym_tlast    (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_symbol_count (symbol_count)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d symbols still due", cycle_count, pending);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_request(input logic [ID_W-1:0] id,
                                                           input logic [LEN_W-1:0] len,
                                                           input logic [63:0] bytes);
        logic [IN_TDATA_W-1:0] r;
        r = '0;
        r[ID_LSB +: ID_W] = id;
        r[LEN_LSB +: LEN_W] = len;
        r[DATA_LSB +: 64] = bytes;
        return r;
    endfunction

    // Present one request, with random idle cycles ahead of it
    task automatic send_request(input logic [CHAN_W-1:0] chan,
                                input logic [IN_TDATA_W-1:0] req);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= chan;
        s_axis_tdata <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        if (chan != SERVED_CHANNEL) rejects_sent++;
    endtask

    // Sender holds off until every due symbol has transferred
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_random_request();
        logic [CHAN_W-1:0] chan;
        logic [LEN_W-1:0] len;
        chan = ($urandom_range(99) < 85) ? SERVED_CHANNEL : CHAN_W'($urandom_range(3, 1));
        len = ($urandom_range(99) < 90) ? LEN_W'($urandom_range(8)) : LEN_W'($urandom_range(15, 9));
        send_request(chan, pack_request(ID_W'($urandom_range(63)), len, {$urandom, $urandom}));
    endtask

    initial begin
        int idle_mix [4];
        int stall_mix [4];
        idle_mix = '{0, 56, 0, 20};
        stall_mix = '{0, 0, 56, 20};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty frame, full frames, carries, saturation, rejects
        send_request(SERVED_CHANNEL, pack_request(6'h00, 4'd0, 64'h0));
        send_request(SERVED_CHANNEL, pack_request(6'h3F, 4'd8, {8{8'hFF}}));
        send_request(SERVED_CHANNEL, pack_request(6'h15, 4'd8, 64'h0));
        send_request(SERVED_CHANNEL, pack_request(6'h2A, 4'd2, {48'h0, 8'h80, 8'h80}));
        send_request(SERVED_CHANNEL, pack_request(6'h2A, 4'd9, 64'h0123456789ABCDEF));
        send_request(SERVED_CHANNEL, pack_request(6'h3F, 4'd15, {8{8'hFF}}));
        send_request(2'd1, pack_request(6'h3F, 4'd8, {8{8'hA5}}));
        send_request(2'd2, pack_request(6'h00, 4'd0, 64'h0));
        send_request(2'd3, pack_request(6'h3F, 4'd15, {8{8'hFF}}));
        for (int i = 0; i < ID_W; i++) begin
            send_request(SERVED_CHANNEL,
                         pack_request(ID_W'(1 << i), LEN_W'(i + 1), {$urandom, $urandom}));
        end
        send_request(SERVED_CHANNEL, pack_request(6'h0C, 4'd7, {8'h00, {7{8'hFE}}}));
        send_request(SERVED_CHANNEL, pack_request(6'h33, 4'd1, 64'hFF));
        send_request(SERVED_CHANNEL, pack_request(6'h3F, 4'd8, 64'h8040201008040201));
        wait_drained();

        // Random traffic over the idle/stall mixes
        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_mix[p];
            stall_pct = stall_mix[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_request();
            wait_drained();
        end

        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d rejected), %0d symbols checked", requests_sent,
                 rejects_sent, symbol_count);
        $display("mixes: no idling, sender idle 56%%, receiver stall 56%%, both 20%%");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
